// ===== rtl/core/ttcw_pkg.sv =====
package ttcw_pkg;

    localparam int IN_W  = 24;
    localparam int OUT_W = 24;

    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DISPATCH,
        S_BLANK,
        S_EXEC,
        S_OUT
    } ttcw_state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic rd;
        logic blank_wr;
        logic exec;
        logic out_load;
    } ttcw_cmd_t;

    typedef struct packed {
        logic is_read;
        logic is_plain;
        logic row_hit;
        logic blank_last;
        logic out_free;
    } ttcw_status_t;

endpackage

// ===== rtl/core/ttcw_ctrl.sv =====
module ttcw_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  ttcw_pkg::ttcw_status_t  status,
    output ttcw_pkg::ttcw_cmd_t     cmd
);
    import ttcw_pkg::*;

    ttcw_state_t state_reg;
    ttcw_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                if (status.is_read)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_OUT;
                end
                else if (status.is_plain && !status.row_hit)
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_BLANK:
            begin
                cmd.blank_wr = 1'b1;
                if (status.blank_last)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/ttcw_datapath.sv =====
module ttcw_datapath #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ttcw_pkg::IN_W-1:0]     in_data,
    input  ttcw_pkg::ttcw_cmd_t           cmd,
    output ttcw_pkg::ttcw_status_t        status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ttcw_pkg::OUT_W-1:0]    out_data
);
    import ttcw_pkg::*;

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);

    logic            mode_reg;
    logic [7:0]      char_reg;
    logic [4:0]      rrow_reg;
    logic [6:0]      rcol_reg;
    logic [CW-1:0]   cnt_reg;
    logic [RW-1:0]   phys_reg;
    logic [CW-1:0]   col_reg;
    logic            tgt_reg;
    logic [7:0]      mem_q_reg;
    logic [7:0]      mem [DEPTH];

    logic [CW-1:0]   cur_col_reg, cur_col_next;
    logic [RW-1:0]   cur_row_reg, cur_row_next;
    logic [RW-1:0]   top_reg, top_next;
    logic [ROWS-1:0] row_valid_reg, row_valid_next;

    logic            out_valid_reg;
    logic [7:0]      out_cell_reg;
    logic [6:0]      out_col_reg;
    logic [4:0]      out_row_reg;

    logic            is_ff, is_nl, is_bs, is_plain;
    logic [6:0]      rr_ext;
    logic [7:0]      rc_ext;
    logic            rd_ok;
    logic [RW-1:0]   sel_row;
    logic [CW-1:0]   sel_col;
    logic            sel_tgt;
    logic [RW:0]     phys_sum;
    logic [RW-1:0]   phys_next;
    logic            row_hit;
    logic            blank_last;
    logic [AW-1:0]   addr;
    logic            we;
    logic [7:0]      wdata;
    logic            scroll;
    logic [7:0]      cell_sel;
    logic [7:0]      col_ext;
    logic [5:0]      row_ext;

    // control byte decode
    always_comb
    begin
        is_ff = 1'b0;
        is_nl = 1'b0;
        is_bs = 1'b0;
        case (char_reg) inside
            CH_FF:        is_ff = 1'b1;
            CH_LF, CH_CR: is_nl = 1'b1;
            CH_BS:        is_bs = 1'b1;
            default:      ;
        endcase
        is_plain = !(is_ff || is_nl || is_bs);
    end

    // target cell of the item, mapped through the circular row offset
    always_comb
    begin
        rr_ext = 7'(rrow_reg);
        rc_ext = 8'(rcol_reg);
        rd_ok  = (rr_ext < 7'(ROWS)) && (rc_ext < 8'(COLS));
        sel_row = '0;
        sel_col = '0;
        sel_tgt = 1'b0;
        if (mode_reg)
        begin
            if (rd_ok)
            begin
                sel_row = rr_ext[RW-1:0];
                sel_col = rc_ext[CW-1:0];
                sel_tgt = 1'b1;
            end
        end
        else if (is_bs)
        begin
            if (cur_col_reg != '0)
            begin
                sel_row = cur_row_reg;
                sel_col = cur_col_reg - 1'b1;
                sel_tgt = 1'b1;
            end
            else if (cur_row_reg != '0)
            begin
                sel_row = cur_row_reg - 1'b1;
                sel_col = COL_LAST;
                sel_tgt = 1'b1;
            end
        end
        else
        begin
            sel_row = cur_row_reg;
            sel_col = cur_col_reg;
            sel_tgt = 1'b1;
        end
        phys_sum = (RW+1)'(top_reg) + (RW+1)'(sel_row);
        if (phys_sum >= (RW+1)'(ROWS))
        begin
            phys_next = RW'(phys_sum - (RW+1)'(ROWS));
        end
        else
        begin
            phys_next = RW'(phys_sum);
        end
    end

    assign row_hit    = row_valid_reg[phys_reg];
    assign blank_last = (cnt_reg == COL_LAST);
    assign addr       = AW'(phys_reg) * AW'(COLS) + AW'(cmd.blank_wr ? cnt_reg : col_reg);
    assign we         = cmd.blank_wr || (cmd.exec && is_plain)
                        || (cmd.exec && is_bs && tgt_reg && row_hit);
    assign wdata      = (cmd.exec && is_plain) ? char_reg : CH_SPACE;

    // screen store, rows not yet valid read as spaces
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            mem_q_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_data[0];
            char_reg <= in_data[8:1];
            rrow_reg <= in_data[13:9];
            rcol_reg <= in_data[20:14];
        end
        if (cmd.load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.blank_wr)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.prep)
        begin
            phys_reg <= phys_next;
            col_reg  <= sel_col;
            tgt_reg  <= sel_tgt;
        end
    end

    // cursor, scroll offset and row valid bits
    always_comb
    begin
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        top_next       = top_reg;
        row_valid_next = row_valid_reg;
        scroll         = 1'b0;
        if (cmd.blank_wr && blank_last)
        begin
            row_valid_next[phys_reg] = 1'b1;
        end
        if (cmd.exec)
        begin
            if (is_ff)
            begin
                row_valid_next = '0;
                top_next       = '0;
                cur_col_next   = '0;
                cur_row_next   = '0;
            end
            else if (is_bs)
            begin
                if (cur_col_reg != '0)
                begin
                    cur_col_next = cur_col_reg - 1'b1;
                end
                else if (cur_row_reg != '0)
                begin
                    cur_row_next = cur_row_reg - 1'b1;
                    cur_col_next = COL_LAST;
                end
            end
            else if (is_nl || cur_col_reg == COL_LAST)
            begin
                cur_col_next = '0;
                if (cur_row_reg == ROW_LAST)
                begin
                    scroll = 1'b1;
                end
                else
                begin
                    cur_row_next = cur_row_reg + 1'b1;
                end
            end
            else
            begin
                cur_col_next = cur_col_reg + 1'b1;
            end
        end
        if (scroll)
        begin
            row_valid_next[top_reg] = 1'b0;
            top_next = (top_reg == ROW_LAST) ? '0 : top_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            top_reg       <= '0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            top_reg       <= top_next;
            row_valid_reg <= row_valid_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        cell_sel = 8'h00;
        if (mode_reg && tgt_reg)
        begin
            cell_sel = row_hit ? mem_q_reg : CH_SPACE;
        end
        col_ext = 8'(cur_col_reg);
        row_ext = 6'(cur_row_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_cell_reg <= cell_sel;
            out_col_reg  <= col_ext[6:0];
            out_row_reg  <= row_ext[4:0];
        end
    end

    assign status.is_read    = mode_reg;
    assign status.is_plain   = is_plain;
    assign status.row_hit    = row_hit;
    assign status.blank_last = blank_last;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = {4'b0000, out_row_reg, out_col_reg, out_cell_reg};

endmodule

// ===== rtl/core/text_terminal_char_writer.sv =====
// character-cell text terminal: a ROWS x COLS screen of bytes with a write cursor
// s_axis carries one command word: put a byte at the cursor, or read one cell
// m_axis returns one word per command: the cell read (0 for a put) and the cursor
// an item is taken at a clk edge with tvalid and tready high on its side
// s_axis_tready is high whenever the block is idle, even while a result waits
// a read passes S_PREP, S_DISPATCH and S_OUT before its result is registered; a put also passes S_EXEC
// an ordinary byte landing in a row not yet written since reset, clear or scroll
// first blanks that row in the screen memory (one cell a cycle)
// a new command is taken only in S_IDLE, after the last one has loaded its result word
// scrolling moves a row offset and clears a row valid bit, no data is copied
// form feed clears all row valid bits at once
// reset (rst_n low) homes the cursor and marks every row blank at once, no sweep
// a stalled m_axis holds its word; one more item is taken and then waits for it
module text_terminal_char_writer #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ttcw_pkg::IN_W-1:0]     s_axis_tdata,  // mode, char_code, read_row, read_col
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ttcw_pkg::OUT_W-1:0]    m_axis_tdata   // cell_char, cursor_col, cursor_row
);
    import ttcw_pkg::*;

    ttcw_cmd_t    cmd;
    ttcw_status_t status;

    ttcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ttcw_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== tb/text_terminal_char_writer_tb.sv =====
`timescale 1ns / 1ps

module text_terminal_char_writer_tb;
    import ttcw_pkg::*;

    localparam int ROWS = 25;
    localparam int COLS = 80;
    localparam int QUIET_LIMIT = 4000;
    localparam logic MODE_PUT = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // fields from the lowest bit up: mode, char_code, read_row, read_col
    typedef struct packed {
        logic [2:0] pad;
        logic [6:0] read_col;
        logic [4:0] read_row;
        logic [7:0] char_code;
        logic       mode;
    } cmd_word_t;

    // fields from the lowest bit up: cell_char, cursor_col, cursor_row
    typedef struct packed {
        logic [3:0] pad;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] cell_char;
    } status_word_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    logic [7:0]   screen_img [ROWS][COLS];
    int unsigned  crs_col;
    int unsigned  crs_row;
    status_word_t status_q [$];
    status_word_t exp_w;
    status_word_t got_w;
    int           errors = 0;
    int           words_sent = 0;
    int           stall_left = 0;
    int           quiet_cycles = 0;
    bit           idle_on = 1'b1;

    text_terminal_char_writer #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void blank_screen();
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                screen_img[r][c] = CH_SPACE;
            end
        end
    endfunction

    function automatic status_word_t terminal_step(cmd_word_t w);
        status_word_t res;
        res = '0;
        if (w.mode == MODE_PUT)
        begin
            if (w.char_code == CH_FF)
            begin
                blank_screen();
                crs_col = 0;
                crs_row = 0;
            end
            else
            begin
                if (w.char_code == CH_LF || w.char_code == CH_CR)
                begin
                    crs_col = 0;
                    crs_row++;
                end
                else if (w.char_code == CH_BS)
                begin
                    if (crs_col > 0)
                    begin
                        crs_col--;
                        screen_img[crs_row][crs_col] = CH_SPACE;
                    end
                    else if (crs_row > 0)
                    begin
                        crs_row--;
                        crs_col = COLS - 1;
                        screen_img[crs_row][crs_col] = CH_SPACE;
                    end
                end
                else
                begin
                    screen_img[crs_row][crs_col] = w.char_code;
                    crs_col++;
                end
                if (crs_col >= COLS)
                begin
                    crs_col = 0;
                    crs_row++;
                end
                if (crs_row >= ROWS)
                begin
                    // scroll up one row, blank the bottom row
                    for (int r = 0; r < ROWS - 1; r++)
                    begin
                        screen_img[r] = screen_img[r + 1];
                    end
                    for (int c = 0; c < COLS; c++)
                    begin
                        screen_img[ROWS - 1][c] = CH_SPACE;
                    end
                    crs_row = ROWS - 1;
                end
            end
        end
        else if (w.read_row < ROWS && w.read_col < COLS)
        begin
            res.cell_char = screen_img[w.read_row][w.read_col];
        end
        res.cursor_col = crs_col[6:0];
        res.cursor_row = crs_row[4:0];
        return res;
    endfunction

    task automatic send_cmd(input logic mode, input logic [7:0] ch,
                            input logic [4:0] rr, input logic [6:0] rc);
        cmd_word_t w;
        w = '{pad: '0, read_col: rc, read_row: rr, char_code: ch, mode: mode};
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        status_q.push_back(terminal_step(w));
        words_sent++;
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_cmd(MODE_PUT, ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
    endtask

    task automatic read_cell(input logic [4:0] rr, input logic [6:0] rc);
        send_cmd(MODE_READ, 8'($urandom_range(0, 255)), rr, rc);
    endtask

    task automatic test_reset_screen();
        read_cell(5'd0, 7'd0);
        read_cell(5'(ROWS - 1), 7'(COLS - 1));
        read_cell(5'd31, 7'd127);
        read_cell(5'd0, 7'(COLS));
        read_cell(5'(ROWS), 7'd0);
    endtask

    task automatic test_plain_bytes();
        put_char(8'h41);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h7F);
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd1);
        read_cell(5'd0, 7'd2);
    endtask

    task automatic test_control_codes();
        put_char(CH_LF);
        put_char(CH_CR);
        // column 0 back to the last column of the row above
        put_char(CH_BS);
        read_cell(5'd1, 7'(COLS - 1));
        put_char(CH_FF);
        read_cell(5'd0, 7'd0);
        // nothing to step back over at home
        put_char(CH_BS);
    endtask

    task automatic test_random_text(input int n_words);
        int stop_at;
        int len;
        int pick;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(0, 199);
            if (pick < 120)
            begin
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(COLS - 4, COLS + 6);
                else
                    len = $urandom_range(0, 6);
                repeat (len)
                begin
                    if ($urandom_range(0, 7) == 0)
                        put_char(8'($urandom_range(0, 255)));
                    else
                        put_char(8'($urandom_range(8'h21, 8'h7E)));
                end
                put_char($urandom_range(0, 1) ? CH_LF : CH_CR);
            end
            else if (pick < 150)
            begin
                repeat ($urandom_range(1, 4)) put_char(CH_BS);
            end
            else if (pick < 195)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    if ($urandom_range(0, 9) == 0)
                        read_cell(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
                    else
                        read_cell(5'($urandom_range(0, ROWS - 1)),
                                  7'($urandom_range(0, COLS - 1)));
                end
            end
            else if (pick < 199)
            begin
                put_char(8'($urandom_range(0, 255)));
            end
            else
            begin
                put_char(CH_FF);
            end
        end
    endtask

    task automatic test_back_to_back(input int n_words);
        idle_on = 1'b0;
        test_random_text(n_words);
    endtask

    always @(posedge clk)
    begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 16);
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            got_w = m_axis_tdata;
            if (status_q.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_w = status_q.pop_front();
                if (got_w.cell_char !== exp_w.cell_char)
                begin
                    $display("%0t: cell_char expected %h actual %h",
                             $time, exp_w.cell_char, got_w.cell_char);
                    errors++;
                end
                if (got_w.cursor_col !== exp_w.cursor_col)
                begin
                    $display("%0t: cursor_col expected %0d actual %0d",
                             $time, exp_w.cursor_col, got_w.cursor_col);
                    errors++;
                end
                if (got_w.cursor_row !== exp_w.cursor_row)
                begin
                    $display("%0t: cursor_row expected %0d actual %0d",
                             $time, exp_w.cursor_row, got_w.cursor_row);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("text_terminal_char_writer test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        blank_screen();
        crs_col = 0;
        crs_row = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_screen();
        test_plain_bytes();
        test_control_codes();
        test_random_text(700);
        test_back_to_back(100);
        s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge clk);
        repeat (COLS + 10) @(posedge clk);
        if (errors == 0)
            $display("text_terminal_char_writer test passed");
        else
            $display("text_terminal_char_writer test failed");
        $finish;
    end

endmodule
